// ===== hw/rtl/mtf_rle_encoder_assert.svh =====
// Assertion macros for the move-to-front / run-length encoder.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MTF_RLE_ENCODER_ASSERT_SVH
`define MTF_RLE_ENCODER_ASSERT_SVH

// Property must hold at every enabled clock edge.
`define MRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mre_pkg.sv =====
// Shared types and constants of the move-to-front / run-length encoder.
// No dependencies.
package mre_pkg;

  localparam int unsigned SYM_W     = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RUN_W     = 7;
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned IDX_BW    = 2;  // index into the byte buffer
  localparam int unsigned CNT_BW    = 3;  // byte count, 0..MAX_BYTES

  localparam logic [BYTE_W-1:0] MARK_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ONE_HIT   = 8'h81;
  localparam logic [RUN_W-1:0]  SHORT_RUN = 7'd2;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } mre_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_burst;
  } mre_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // input request accepted: latch symbol, compare cells
    logic update;    // move cells, update run, build byte list
    logic advance;   // output request taken
  } mre_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_bytes; // update produces at least one byte
    logic last_byte; // byte on the output is the last of the burst
  } mre_status_t;

endpackage

// ===== hw/rtl/mre_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T.
// No dependencies.
interface mre_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mre_ctrl.sv =====
// Controller of the encoder: idle / update / emit sequencing.
// Depends on mre_pkg and mtf_rle_encoder_assert.svh.
`include "mtf_rle_encoder_assert.svh"

module mre_ctrl import mre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  mre_status_t status_i,
  output mre_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.update  = (state_q == ST_UPDATE);
  assign cmd_o.advance = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = status_i.has_bytes ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cmd_o.advance && status_i.last_byte) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MRE_ASSERT_NXT(a_silent_update_idles, (state_q == ST_UPDATE) && !status_i.has_bytes,
                  state_q == ST_IDLE, "update without bytes did not return to idle")
  `MRE_ASSERT_NXT(a_burst_end_idles, cmd_o.advance && status_i.last_byte,
                  state_q == ST_IDLE, "burst end did not return to idle")

endmodule

// ===== hw/rtl/mre_dpath.sv =====
// Datapath of the encoder: dictionary cell row, run counter, byte buffer.
// Depends on mre_pkg and mtf_rle_encoder_assert.svh.
`include "mtf_rle_encoder_assert.svh"

module mre_dpath import mre_pkg::*; #(
  parameter int unsigned ALPHABET = 128,
  parameter int unsigned RUN_MAX  = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mre_cmd_t    cmd_i,
  input  mre_in_t     in_i,
  output mre_out_t    out_o,
  output mre_status_t status_o
);

  localparam int unsigned IDX_W  = $clog2(ALPHABET);
  localparam int unsigned SIZE_W = $clog2(ALPHABET + 1);

  logic [SYM_W-1:0]   dict_q [ALPHABET];
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [SYM_W-1:0]   sym_q;
  logic               last_q;
  logic [ALPHABET-1:0] hit_q;
  logic [BYTE_W-1:0]  buf_q [MAX_BYTES];
  logic [BYTE_W-1:0]  buf_d [MAX_BYTES];
  logic [CNT_BW-1:0]  cnt_q, cnt_d;
  logic [IDX_BW-1:0]  idx_q;

  logic               hit_any, front_hit, full, flush;
  logic [IDX_W-1:0]   hit_idx, wr_idx;
  logic [SIZE_W-1:0]  pos;
  logic [BYTE_W-1:0]  pos_byte;
  logic [RUN_W-1:0]   run_inc, flush_n;
  logic [BYTE_W-1:0]  fb0, fb1, eb0, eb1;
  logic [1:0]         fcnt, ecnt;

  // Capture: latch request, compare every valid cell against the symbol.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q  <= in_i.symbol;
      last_q <= in_i.last;
      for (int i = 0; i < ALPHABET; i++) begin
        hit_q[i] <= (SIZE_W'(i) < size_q) && (dict_q[i] == in_i.symbol);
      end
    end
  end

  // Cells hold distinct symbols, so the hit vector is one-hot or empty.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (hit_q[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  assign hit_any   = |hit_q;
  assign front_hit = hit_any && (hit_idx == '0);
  assign full      = (size_q == SIZE_W'(ALPHABET));
  assign wr_idx    = full ? IDX_W'(ALPHABET - 1) : size_q[IDX_W-1:0];

  always_comb begin
    if (hit_any)   pos = SIZE_W'(hit_idx) + SIZE_W'(1);
    else if (full) pos = SIZE_W'(ALPHABET);
    else           pos = size_q + SIZE_W'(1);
  end

  // 128 + position, modulo 256
  assign pos_byte = MARK_BASE + BYTE_W'(pos);

  // Run bookkeeping
  assign run_inc = run_q + RUN_W'(1);
  assign flush   = (run_inc >= RUN_W'(RUN_MAX)) || last_q;

  always_comb begin
    if (front_hit) begin
      flush_n = flush ? run_inc : '0;
      run_d   = flush ? '0 : run_inc;
    end else begin
      flush_n = run_q;
      run_d   = '0;
    end
  end

  // Flushed run: short runs repeat 129, longer ones become marker + count.
  always_comb begin
    fb0  = ONE_HIT;
    fb1  = ONE_HIT;
    fcnt = 2'd0;
    if (flush_n > SHORT_RUN) begin
      fb0  = MARK_BASE;
      fb1  = {1'b1, flush_n};
      fcnt = 2'd2;
    end else if (flush_n == SHORT_RUN) begin
      fcnt = 2'd2;
    end else if (flush_n != '0) begin
      fcnt = 2'd1;
    end
  end

  // Symbol bytes: none for a front hit, position for a hit, position and
  // literal for a new symbol.
  always_comb begin
    eb0  = pos_byte;
    eb1  = {1'b0, sym_q};
    if (front_hit)    ecnt = 2'd0;
    else if (hit_any) ecnt = 2'd1;
    else              ecnt = 2'd2;
  end

  always_comb begin
    buf_d[0] = eb0;
    buf_d[1] = eb1;
    buf_d[2] = eb1;
    buf_d[3] = eb1;
    unique case (fcnt)
      2'd1: begin
        buf_d[0] = fb0;
        buf_d[1] = eb0;
        buf_d[2] = eb1;
      end
      2'd2: begin
        buf_d[0] = fb0;
        buf_d[1] = fb1;
        buf_d[2] = eb0;
        buf_d[3] = eb1;
      end
      default: ;
    endcase
  end

  assign cnt_d  = CNT_BW'(fcnt) + CNT_BW'(ecnt);
  assign size_d = (!hit_any && !full) ? size_q + SIZE_W'(1) : size_q;

  // Cell row: on a hit, cells up to the hit shift back and the symbol goes
  // to the front; a new symbol lands at the end (or replaces the last cell).
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < ALPHABET; i++) begin
        if (hit_any) begin
          if (i == 0)                          dict_q[i] <= sym_q;
          else if (hit_idx >= IDX_W'(i))       dict_q[i] <= dict_q[i-1];
        end else if (wr_idx == IDX_W'(i)) begin
          dict_q[i] <= sym_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int j = 0; j < MAX_BYTES; j++) buf_q[j] <= buf_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      run_q  <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (cmd_i.update) begin
      size_q <= size_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      idx_q  <= '0;
    end else if (cmd_i.advance) begin
      idx_q  <= idx_q + IDX_BW'(1);
    end
  end

  assign status_o.has_bytes = (cnt_d != '0);
  assign status_o.last_byte = (CNT_BW'(idx_q) == cnt_q - CNT_BW'(1));

  assign out_o.out_byte     = buf_q[idx_q];
  assign out_o.end_of_burst = status_o.last_byte;

  `MRE_ASSERT_IMP(a_hit_unique, cmd_i.update, $onehot0(hit_q),
                  "symbol matched more than one dictionary cell")
  `MRE_ASSERT(a_run_below_max, run_q < RUN_W'(RUN_MAX), "held run reached saturation")
  `MRE_ASSERT(a_size_bound, size_q <= SIZE_W'(ALPHABET), "dictionary size out of range")

endmodule

// ===== hw/rtl/mtf_rle_encoder.sv =====
// Top level of the move-to-front / run-length encoder.
// Depends on mre_pkg, mre_stream_if, mre_ctrl and mre_dpath.

// Each input request carries one 7-bit symbol and a last flag. The symbol is
// looked up in a move-to-front dictionary of up to ALPHABET entries that
// starts empty after reset and is kept across streams. A known symbol at
// one-based position p moves to the front and yields byte 128 + p (mod 256,
// so position 128 gives byte 0); an unseen symbol is appended (or replaces
// the last entry when the dictionary is full) and yields 128 + its position
// followed by the symbol as a literal. Hits at position 1 are held as a run:
// a run is flushed when another kind of symbol arrives, when it reaches
// RUN_MAX, or on last. Runs of one or two emit 129 per hit; longer runs emit
// 128 followed by 128 + count. Each input causes 0 to 4 output requests;
// end_of_burst marks the last of them.
// Timing: one symbol at a time. The input is taken in the idle cycle, where
// all dictionary cells compare against the symbol in parallel; the next
// cycle moves the cells and builds the byte list. Bytes then leave one per
// cycle from a 4-entry buffer as the sink takes them, and ready is high
// again once the last byte is taken.
module mtf_rle_encoder import mre_pkg::*; #(
  parameter int unsigned ALPHABET = 128,
  parameter int unsigned RUN_MAX  = 127
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mre_stream_if.sink   in_i,
  mre_stream_if.source out_o
);

  mre_cmd_t    cmd;
  mre_status_t status;
  mre_in_t     in_payload;
  mre_out_t    out_payload;

  assign in_payload    = in_i.payload;
  assign out_o.payload = out_payload;

  // sequencing: idle -> update -> emit bytes (if any)
  mre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // dictionary cells, run counter and output byte buffer
  mre_dpath #(
    .ALPHABET (ALPHABET),
    .RUN_MAX  (RUN_MAX)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_i     (in_payload),
    .out_o    (out_payload),
    .status_o (status)
  );

endmodule
